@@ design/pfb_pkg.sv @@
package pfb_pkg;

	// Fixed geometry of one panel and the default size of the byte store.
	localparam int PANEL_BYTES    = 64;
	localparam int MAX_PANELS_DEF = 8;

	// Coordinate widths: request fields and widened plot coordinates.
	localparam int COORD_W = 11;
	localparam int PT_W    = 13;
	// Width of byte addresses and counts before they are cut to the store.
	localparam int ADDR_W  = 11;

	// Request payload layout on s_tdata, lowest bit first.
	localparam int TD_W       = 72;
	localparam int TD_XA_LSB  = 0;
	localparam int TD_YA_LSB  = 11;
	localparam int TD_XB_LSB  = 22;
	localparam int TD_YB_LSB  = 33;
	localparam int TD_RAD_LSB = 44;
	localparam int TD_MOD_LSB = 54;
	localparam int TD_ON_BIT  = 57;
	localparam int TD_RA_LSB  = 58;

	// Command codes carried on s_tuser.
	localparam logic [2:0] ACT_PIXEL  = 3'd0;
	localparam logic [2:0] ACT_LINE   = 3'd1;
	localparam logic [2:0] ACT_CIRCLE = 3'd2;
	localparam logic [2:0] ACT_FILL   = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// Pixel combine modes.
	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_INVERSE = 3'd1;
	localparam logic [2:0] MODE_TOGGLE  = 3'd2;
	localparam logic [2:0] MODE_OR      = 3'd3;
	localparam logic [2:0] MODE_NOR     = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_PANELS_WIDE = 1'b0;
	localparam logic CFG_PANELS_HIGH = 1'b1;

	localparam logic [7:0] DARK_BYTE = 8'hff;
	localparam logic [7:0] LIT_BYTE  = 8'h00;
	localparam logic [7:0] MSB_MASK  = 8'h80;

	// Where the plotted point comes from.
	typedef enum logic [1:0] {
		SRC_PIXEL  = 2'd0,
		SRC_LINE   = 2'd1,
		SRC_CIRCLE = 2'd2
	} pfb_src_t;

	typedef struct packed {
		logic     load;
		logic     clr_step;
		logic     fill_step;
		logic     line_init;
		logic     line_step;
		logic     circ_init;
		logic     circ_step;
		logic     pt_next;
		logic     pix_rd;
		logic     pix_wr;
		logic     rd_issue;
		logic     out_load;
		pfb_src_t src;
	} pfb_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic fill_last;
		logic line_done;
		logic circ_done;
		logic pt_last;
	} pfb_sts_t;

endpackage

@@ design/panel_frame_buffer_draw_engine_core.sv @@
// Channel   | Signals                              | Contents
// ----------+--------------------------------------+-----------------------------------
// request   | s_tvalid s_tready s_tdata s_tuser    | one draw, clear/fill or read command
// result    | m_tvalid m_tready m_tdata            | read byte, zero for other commands
// config    | cfg_wr_en cfg_index cfg_data         | panel grid size, write only
//
// A pixel write reads its byte and then writes it back; a line does so for every plotted
// pixel, a circle for eight octant slots per midpoint step (each a read and a write of the
// byte store); a clear or fill writes each active byte in turn, and a read does one store read.
// After reset a clearing pass sets all MAX_PANELS*64 bytes of the store to 0xFF while
// s_tready stays low; configuration writes are taken during it.
// One request is worked on at a time. The result sits in an output register, so a stalled
// m_tready does not stop the next request being taken; only its result then waits for the register.
module panel_frame_buffer_draw_engine_core #(
	parameter int MAX_PANELS = pfb_pkg::MAX_PANELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// s_tdata, lowest bit first: x_a[10:0], y_a[21:11], x_b[32:22], y_b[43:33],
	// radius[53:44], mode[56:54], pixel_on[57], read_addr[66:58], zero fill.
	input  logic [pfb_pkg::TD_W-1:0] s_tdata,
	// s_tuser: action[2:0].
	input  logic [2:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// m_tdata: read_data[7:0].
	output logic [7:0]               m_tdata,
	input  logic                     cfg_wr_en,
	input  logic                     cfg_index,
	input  logic [2:0]               cfg_data
);
	import pfb_pkg::*;

	localparam int Depth = MAX_PANELS * PANEL_BYTES;

	pfb_cmd_t cmd;
	pfb_sts_t sts;

	// The controller sequences each request: it chooses the point source,
	// issues the read and the write of every pixel, and walks the sweeps.
	pfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the line and circle walkers, the address and clip
	// logic, the byte store and the result register.
	pfb_dp #(
		.Depth (Depth)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.action    (s_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_tdata)
	);

	// Every byte write of a pixel follows the read of that same byte.
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> $past(cmd.pix_rd))
		else $error("pixel write without preceding read");

	// No request may be taken while the store is still being cleared.
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !s_tready)
		else $error("request accepted during clearing pass");

	// A result appears only when the controller loads the output register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without load");

	// A request is only taken from the idle point, never mid-command.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.pix_wr && !cmd.fill_step && !cmd.out_load)
		else $error("request accepted while busy");

endmodule

@@ design/pfb_ctrl.sv @@
module pfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [2:0]        action,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pfb_pkg::pfb_cmd_t cmd,
	input  pfb_pkg::pfb_sts_t sts
);
	import pfb_pkg::*;

	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_LINIT = 9'b000000100,
		ST_CINIT = 9'b000001000,
		ST_PRD   = 9'b000010000,
		ST_PWR   = 9'b000100000,
		ST_FILL  = 9'b001000000,
		ST_RDC   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t   state_q, state_d;
	pfb_src_t kind_q, kind_d;
	logic     m_tvalid_q;

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.src  = kind_q;
		s_tready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (action)
						ACT_PIXEL: begin
							kind_d  = SRC_PIXEL;
							state_d = ST_PRD;
						end
						ACT_LINE: begin
							kind_d  = SRC_LINE;
							state_d = ST_LINIT;
						end
						ACT_CIRCLE: begin
							kind_d  = SRC_CIRCLE;
							state_d = ST_CINIT;
						end
						ACT_FILL:  state_d = ST_FILL;
						ACT_READ:  state_d = ST_RDC;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_LINIT: begin
				cmd.line_init = 1'b1;
				state_d       = ST_PRD;
			end
			ST_CINIT: begin
				cmd.circ_init = 1'b1;
				state_d       = ST_PRD;
			end
			ST_PRD: begin
				cmd.pix_rd = 1'b1;
				state_d    = ST_PWR;
			end
			ST_PWR: begin
				cmd.pix_wr = 1'b1;
				case (kind_q)
					SRC_LINE: begin
						if (sts.line_done) begin
							state_d = ST_DONE;
						end else begin
							cmd.line_step = 1'b1;
							state_d       = ST_PRD;
						end
					end
					SRC_CIRCLE: begin
						if (!sts.pt_last) begin
							cmd.pt_next = 1'b1;
							state_d     = ST_PRD;
						end else if (sts.circ_done) begin
							state_d = ST_DONE;
						end else begin
							cmd.circ_step = 1'b1;
							state_d       = ST_PRD;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_DONE;
				end
			end
			ST_RDC: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			kind_q     <= SRC_PIXEL;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/pfb_dp.sv @@
module pfb_dp #(
	parameter int Depth = pfb_pkg::MAX_PANELS_DEF * pfb_pkg::PANEL_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [pfb_pkg::TD_W-1:0] s_tdata,
	input  logic [2:0]             action,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [2:0]             cfg_data,
	input  pfb_pkg::pfb_cmd_t      cmd,
	output pfb_pkg::pfb_sts_t      sts,
	output logic [7:0]             out_data
);
	import pfb_pkg::*;

	localparam int AW = $clog2(Depth);

	// Configuration and the saturated panel counts.
	logic [2:0] panels_wide_q, weff;
	logic [1:0] panels_high_q, heff;
	logic [4:0] wh;

	// Latched request.
	logic [2:0]                act_q, mode_q;
	logic signed [COORD_W-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [9:0]                radius_q;
	logic                      on_q;
	logic [8:0]                rdaddr_q;

	// Line walker.
	logic signed [COORD_W-1:0] lx_q, ly_q;
	logic                      sx_q, sy_q, xmaj_q;
	logic [12:0]               ldx2_q, ldy2_q;
	logic signed [14:0]        lf_q;
	logic signed [11:0]        ddx, ddy;
	logic [11:0]               adx, ady;
	logic [12:0]               dx2, dy2;
	logic signed [14:0]        f_step;

	// Circle walker.
	logic [10:0]        cix_q, ciy_q, x1, ynew, ca, cb;
	logic signed [15:0] cp_q, cdiff;
	logic [2:0]         k_q;
	logic               cen;

	// Plot point and byte address.
	logic signed [PT_W-1:0] px, py, ca13, cb13;
	logic                   pen, pon, on_grid, pok;
	logic [ADDR_W-1:0]      pa, pa_q, fill_n, rd_ext;
	logic [6:0]             row_pitch;
	logic [7:0]             pmask, pmask_q, newbyte;
	logic                   pok_q, pon_q;

	// Store.
	logic [7:0]    mem [Depth];
	logic [AW-1:0] cnt_q, waddr, raddr;
	logic [7:0]    wdata, rdata_q;
	logic          we, re, rok_q;
	logic [7:0]    out_q;

	assign weff = (panels_wide_q == 3'd0) ? 3'd1 : (panels_wide_q > 3'd4) ? 3'd4 : panels_wide_q;
	assign heff = (panels_high_q == 2'd0) ? 2'd1 : (panels_high_q > 2'd2) ? 2'd2 : panels_high_q;
	assign wh   = 5'(weff) * 5'(heff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panels_wide_q <= 3'd1;
			panels_high_q <= 2'd1;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_PANELS_WIDE) begin
				panels_wide_q <= cfg_data;
			end else begin
				panels_high_q <= cfg_data[1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			xa_q     <= s_tdata[TD_XA_LSB +: COORD_W];
			ya_q     <= s_tdata[TD_YA_LSB +: COORD_W];
			xb_q     <= s_tdata[TD_XB_LSB +: COORD_W];
			yb_q     <= s_tdata[TD_YB_LSB +: COORD_W];
			radius_q <= s_tdata[TD_RAD_LSB +: 10];
			mode_q   <= s_tdata[TD_MOD_LSB +: 3];
			on_q     <= s_tdata[TD_ON_BIT];
			rdaddr_q <= s_tdata[TD_RA_LSB +: 9];
		end
	end

	// Line setup and one Bresenham step.
	assign ddx = 12'(xb_q) - 12'(xa_q);
	assign ddy = 12'(yb_q) - 12'(ya_q);
	assign adx = ddx[11] ? 12'(-ddx) : 12'(ddx);
	assign ady = ddy[11] ? 12'(-ddy) : 12'(ddy);
	assign dx2 = {adx, 1'b0};
	assign dy2 = {ady, 1'b0};
	assign f_step = xmaj_q
		? lf_q + $signed({2'b0, ldy2_q}) - ((lf_q >= 0) ? $signed({2'b0, ldx2_q}) : 15'sd0)
		: lf_q + $signed({2'b0, ldx2_q}) - ((lf_q >= 0) ? $signed({2'b0, ldy2_q}) : 15'sd0);

	always_ff @(posedge clk) begin
		if (cmd.line_init) begin
			lx_q   <= xa_q;
			ly_q   <= ya_q;
			sx_q   <= ddx[11];
			sy_q   <= ddy[11];
			ldx2_q <= dx2;
			ldy2_q <= dy2;
			xmaj_q <= dx2 > dy2;
			lf_q   <= (dx2 > dy2) ? $signed({2'b0, dy2}) - $signed({3'b0, adx})
			                      : $signed({2'b0, dx2}) - $signed({3'b0, ady});
		end else if (cmd.line_step) begin
			lf_q <= f_step;
			if (xmaj_q || lf_q >= 0) begin
				lx_q <= sx_q ? lx_q - 11'sd1 : lx_q + 11'sd1;
			end
			if (!xmaj_q || lf_q >= 0) begin
				ly_q <= sy_q ? ly_q - 11'sd1 : ly_q + 11'sd1;
			end
		end
	end

	// Midpoint circle step; the eight octant points are walked by k_q.
	assign x1    = cix_q + 11'd1;
	assign ynew  = ciy_q - 11'd1;
	assign cdiff = $signed({5'b0, x1}) - $signed({5'b0, ynew});

	always_ff @(posedge clk) begin
		if (cmd.circ_init) begin
			cix_q <= 11'd0;
			ciy_q <= {1'b0, radius_q};
			k_q   <= 3'd0;
			if (radius_q == 10'd0) begin
				cp_q <= 16'sd1;
			end else if (radius_q == 10'd1) begin
				cp_q <= 16'sd0;
			end else begin
				cp_q <= 16'sd2 - $signed({6'b0, radius_q});
			end
		end else if (cmd.circ_step) begin
			k_q   <= 3'd0;
			cix_q <= x1;
			if (cp_q < 0) begin
				cp_q <= cp_q + $signed({4'b0, x1, 1'b0}) + 16'sd1;
			end else begin
				ciy_q <= ynew;
				cp_q  <= cp_q + $signed({cdiff[14:0], 1'b0}) + 16'sd1;
			end
		end else if (cmd.pt_next) begin
			k_q <= k_q + 3'd1;
		end
	end

	// On the axes only four distinct points exist; past the diagonal none.
	assign cen = (cix_q == 11'd0)
		? (k_q == 3'd0 || k_q == 3'd2 || k_q == 3'd4 || k_q == 3'd5)
		: (cix_q <= ciy_q) && (!k_q[2] || cix_q < ciy_q);
	assign ca   = k_q[2] ? ciy_q : cix_q;
	assign cb   = k_q[2] ? cix_q : ciy_q;
	assign ca13 = $signed({2'b0, ca});
	assign cb13 = $signed({2'b0, cb});

	always_comb begin
		case (cmd.src)
			SRC_LINE: begin
				px  = PT_W'(lx_q);
				py  = PT_W'(ly_q);
				pen = 1'b1;
				pon = 1'b1;
			end
			SRC_CIRCLE: begin
				px  = PT_W'(xa_q) + (k_q[0] ? -ca13 : ca13);
				py  = PT_W'(ya_q) + (k_q[1] ? -cb13 : cb13);
				pen = cen;
				pon = 1'b1;
			end
			default: begin
				px  = PT_W'(xa_q);
				py  = PT_W'(ya_q);
				pen = 1'b1;
				pon = on_q;
			end
		endcase
	end

	assign on_grid = !px[PT_W-1] && !py[PT_W-1]
		&& ($unsigned(px) < PT_W'({weff, 5'b0}))
		&& ($unsigned(py) < PT_W'({heff, 4'b0}));
	assign row_pitch = {wh, 2'b0};
	assign pa = ADDR_W'(px[6:3]) + (py[4] ? ADDR_W'({weff, 2'b0}) : '0)
		+ ADDR_W'(py[3:0]) * ADDR_W'(row_pitch);
	assign pok   = pen && on_grid && (pa < ADDR_W'(Depth));
	assign pmask = MSB_MASK >> px[2:0];

	always_ff @(posedge clk) begin
		if (cmd.pix_rd) begin
			pa_q    <= pa;
			pok_q   <= pok;
			pon_q   <= pon;
			pmask_q <= pmask;
		end
	end

	always_comb begin
		case (mode_q)
			MODE_NORMAL:  newbyte = pon_q ? (rdata_q & ~pmask_q) : (rdata_q | pmask_q);
			MODE_INVERSE: newbyte = pon_q ? (rdata_q | pmask_q) : (rdata_q & ~pmask_q);
			MODE_TOGGLE:  newbyte = pon_q ? (rdata_q ^ pmask_q) : rdata_q;
			MODE_OR:      newbyte = pon_q ? (rdata_q & ~pmask_q) : rdata_q;
			MODE_NOR:     newbyte = pon_q ? (rdata_q | pmask_q) : rdata_q;
			default:      newbyte = rdata_q;
		endcase
	end

	// Sweep counter shared by the reset clearing pass and clear/fill.
	assign fill_n = ((ADDR_W'(wh) << 6) < ADDR_W'(Depth)) ? (ADDR_W'(wh) << 6) : ADDR_W'(Depth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.clr_step || cmd.fill_step) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign sts.clr_last  = cnt_q == AW'(Depth - 1);
	assign sts.fill_last = ADDR_W'(cnt_q) == fill_n - ADDR_W'(1);
	assign sts.line_done = xmaj_q ? (lx_q == xb_q) : (ly_q == yb_q);
	assign sts.circ_done = !(cix_q < ciy_q);
	assign sts.pt_last   = k_q == 3'd7;

	assign rd_ext = ADDR_W'(rdaddr_q);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = DARK_BYTE;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.fill_step) begin
			we    = 1'b1;
			wdata = on_q ? LIT_BYTE : DARK_BYTE;
		end else if (cmd.pix_wr) begin
			we    = pok_q;
			waddr = pa_q[AW-1:0];
			wdata = newbyte;
		end
	end

	assign re    = cmd.pix_rd || cmd.rd_issue;
	assign raddr = cmd.rd_issue ? rd_ext[AW-1:0] : pa[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (cmd.rd_issue) begin
			rok_q <= rd_ext < ADDR_W'(Depth);
		end
		if (cmd.out_load) begin
			out_q <= (act_q == ACT_READ && rok_q) ? rdata_q : 8'h00;
		end
	end

	assign out_data = out_q;

endmodule
